### src/scpi_number_parse_median3_top_defines.svh
// Assertion helpers shared by the parser modules
`ifndef SCPI_NUMBER_PARSE_MEDIAN3_TOP_DEFINES_SVH
`define SCPI_NUMBER_PARSE_MEDIAN3_TOP_DEFINES_SVH

// same-cycle implication
`define SNPM3_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("snpm3 check failed");

// next-cycle implication
`define SNPM3_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("snpm3 check failed");

`endif

### src/snpm3_pkg.sv
package snpm3_pkg;

  localparam int LINE_CHARS_DEF = 256;
  localparam logic [4:0] SCALE_RST = 5'd3;
  localparam int MAX_EXP = 16;
  localparam int MIN_EXP = -50;
  // 10^20 exceeds 2^64, so more divides only give zero
  localparam int DIV_CAP = 20;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_NAN = 2'd1;
  localparam logic [1:0] ST_EXP = 2'd2;

  typedef enum logic [2:0] {
    PH_BLANK, PH_SIGN, PH_INT, PH_FRAC, PH_EXPSIGN, PH_EXPDIG, PH_DONE, PH_BAD
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_FLOAD, S_FRUN, S_FDIV, S_FSAVE,
    S_ILOAD, S_IRUN, S_IDIV, S_ISAVE, S_SUM, S_NEG, S_WRITE
  } ctrl_state_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] ch;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         parse_status;
    logic signed [63:0] parsed_value;
    logic signed [63:0] median_value;
    logic               median_valid;
  } out_word_t;

  typedef struct packed {
    logic take;
    logic clear;
    logic setup;
    logic load_frac;
    logic load_int;
    logic mul;
    logic div_step;
    logic save_frac;
    logic save_int;
    logic sum;
    logic neg;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic req;
    logic term;
    logic full;
    logic skip;
    logic steps_zero;
    logic mode_div;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

### src/snpm3_ctrl.sv
`include "scpi_number_parse_median3_top_defines.svh"

module snpm3_ctrl
  import snpm3_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !sts.req && (sts.term || sts.full)) state_nxt = S_SETUP;
      end
      S_SETUP: state_nxt = sts.skip ? S_WRITE : S_FLOAD;
      S_FLOAD: state_nxt = S_FRUN;
      S_FRUN: begin
        if (sts.steps_zero) state_nxt = S_FSAVE;
        else if (sts.mode_div) state_nxt = S_FDIV;
      end
      S_FDIV: if (sts.div_last) state_nxt = S_FRUN;
      S_FSAVE: state_nxt = S_ILOAD;
      S_ILOAD: state_nxt = S_IRUN;
      S_IRUN: begin
        if (sts.steps_zero) state_nxt = S_ISAVE;
        else if (sts.mode_div) state_nxt = S_IDIV;
      end
      S_IDIV: if (sts.div_last) state_nxt = S_IRUN;
      S_ISAVE: state_nxt = S_SUM;
      S_SUM: state_nxt = S_NEG;
      S_NEG: state_nxt = S_WRITE;
      S_WRITE: if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.clear = accept && sts.req;
        cmd.take  = accept && !sts.req && !sts.term;
      end
      S_SETUP: cmd.setup = 1'b1;
      S_FLOAD: cmd.load_frac = 1'b1;
      S_ILOAD: cmd.load_int = 1'b1;
      S_FRUN, S_IRUN: cmd.mul = !sts.steps_zero && !sts.mode_div;
      S_FDIV, S_IDIV: cmd.div_step = 1'b1;
      S_FSAVE: cmd.save_frac = 1'b1;
      S_ISAVE: cmd.save_int = 1'b1;
      S_SUM: cmd.sum = 1'b1;
      S_NEG: cmd.neg = 1'b1;
      S_WRITE: cmd.write = sts.out_free;
      default: cmd = '0;
    endcase
  end

  `SNPM3_AST_NXT(a_term_setup, accept && !sts.req && sts.term, state_r == S_SETUP)
  `SNPM3_AST_NXT(a_clear_idle, accept && sts.req, state_r == S_IDLE)
  `SNPM3_AST_NXT(a_div_hold, state_r == S_FDIV && !sts.div_last, state_r == S_FDIV)

endmodule

### src/snpm3_dp.sv
`include "scpi_number_parse_median3_top_defines.svh"

module snpm3_dp
  import snpm3_pkg::*;
#(
  parameter int LINE_CHARS = LINE_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_word_t   in_word,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  input  cmd_t       cmd,
  output sts_t       sts,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_word
);

  localparam int LEN_W = $clog2(LINE_CHARS + 1);

  logic [4:0]         scale_r;
  phase_t             phase_r, phase_nxt;
  logic               mneg_r, mneg_nxt;
  logic [63:0]        iacc_r, iacc_nxt;
  logic [63:0]        facc_r, facc_nxt;
  logic [7:0]         fdig_r, fdig_nxt;
  logic [9:0]         emag_r, emag_nxt;
  logic               eneg_r, eneg_nxt;
  logic [LEN_W-1:0]   len_r, len_inc;
  logic signed [11:0] e_r, e_c;
  logic [1:0]         stat_r, stat_c;
  logic [63:0]        w_r, val_r;
  logic               wneg_r, mode_div_r;
  logic [4:0]         steps_r;
  logic [2:0]         div_cnt_r;
  logic [3:0]         rem_r, rem_c;
  logic [7:0]         qbyte;
  logic [63:0]        hist_r [3];
  logic [1:0]         hcnt_r;
  out_word_t          out_r;
  logic               out_valid_r;
  logic               dig;
  logic [3:0]         dv;
  logic [13:0]        emag_ext;
  logic signed [12:0] kf;

  function automatic logic [63:0] times10(input logic [63:0] x);
    return (x << 3) + (x << 1);
  endfunction

  function automatic logic [63:0] med3(input logic [63:0] a, input logic [63:0] b,
                                       input logic [63:0] c);
    logic ab, ac, bc;
    ab = $signed(a) <= $signed(b);
    ac = $signed(a) <= $signed(c);
    bc = $signed(b) <= $signed(c);
    if ((!ab && ac) || (ab && !ac) || (ab && ac && $signed(a) == $signed(b)) ||
        (!ac && !ab && $signed(a) == $signed(c)))
      return a;
    if ((ab && bc) || (!bc && !ab))
      return b;
    return c;
  endfunction

  // character classification
  assign dig      = in_word.ch >= CH_ZERO && in_word.ch <= CH_NINE;
  assign dv       = in_word.ch[3:0];
  assign emag_ext = {4'd0, emag_r} * 14'd10 + {10'd0, dv};
  assign len_inc  = len_r + 1'b1;

  // per-character parse step
  always_comb begin
    phase_nxt = phase_r;
    mneg_nxt  = mneg_r;
    iacc_nxt  = iacc_r;
    facc_nxt  = facc_r;
    fdig_nxt  = fdig_r;
    emag_nxt  = emag_r;
    eneg_nxt  = eneg_r;
    case (phase_r)
      PH_BLANK: begin
        if (in_word.ch == CH_SP || in_word.ch == CH_TAB) phase_nxt = PH_BLANK;
        else if (in_word.ch == CH_MINUS) begin
          mneg_nxt  = 1'b1;
          phase_nxt = PH_SIGN;
        end else if (in_word.ch == CH_PLUS) phase_nxt = PH_SIGN;
        else if (dig) begin
          iacc_nxt  = times10(iacc_r) + {60'd0, dv};
          phase_nxt = PH_INT;
        end else if (in_word.ch == CH_POINT) phase_nxt = PH_FRAC;
        else phase_nxt = PH_BAD;
      end
      PH_SIGN: begin
        if (dig) begin
          iacc_nxt  = times10(iacc_r) + {60'd0, dv};
          phase_nxt = PH_INT;
        end else if (in_word.ch == CH_POINT) phase_nxt = PH_FRAC;
        else phase_nxt = PH_BAD;
      end
      PH_INT: begin
        if (dig) iacc_nxt = times10(iacc_r) + {60'd0, dv};
        else if (in_word.ch == CH_POINT) phase_nxt = PH_FRAC;
        else if (in_word.ch == CH_E_LO || in_word.ch == CH_E_UP) phase_nxt = PH_EXPSIGN;
        else phase_nxt = PH_DONE;
      end
      PH_FRAC: begin
        if (dig) begin
          facc_nxt = times10(facc_r) + {60'd0, dv};
          if (fdig_r != 8'hFF) fdig_nxt = fdig_r + 8'd1;
        end else if (in_word.ch == CH_E_LO || in_word.ch == CH_E_UP) phase_nxt = PH_EXPSIGN;
        else phase_nxt = PH_DONE;
      end
      PH_EXPSIGN, PH_EXPDIG: begin
        if (dig) begin
          emag_nxt  = (emag_ext > 14'd1023) ? 10'd1023 : emag_ext[9:0];
          phase_nxt = PH_EXPDIG;
        end else if (phase_r == PH_EXPSIGN && in_word.ch == CH_MINUS) begin
          eneg_nxt  = 1'b1;
          phase_nxt = PH_EXPDIG;
        end else if (phase_r == PH_EXPSIGN && in_word.ch == CH_PLUS) phase_nxt = PH_EXPDIG;
        else phase_nxt = PH_DONE;
      end
      default: phase_nxt = phase_r;
    endcase
  end

  // effective exponent and status at line end
  always_comb begin
    e_c = eneg_r ? -$signed({2'b00, emag_r}) : $signed({2'b00, emag_r});
    e_c = e_c + $signed({7'd0, scale_r});
    if (phase_r == PH_BLANK || phase_r == PH_SIGN || phase_r == PH_BAD) stat_c = ST_NAN;
    else if (e_c > 12'(MAX_EXP)) stat_c = ST_EXP;
    else stat_c = ST_OK;
  end

  assign kf = $signed({5'd0, fdig_r}) - 13'(e_r);

  // divide by ten, one byte of quotient a cycle
  always_comb begin
    logic [4:0] t;
    rem_c = (div_cnt_r == 3'd0) ? 4'd0 : rem_r;
    qbyte = '0;
    for (int i = 7; i >= 0; i--) begin
      t = {rem_c, w_r[56 + i]};
      if (t >= 5'd10) begin
        t = t - 5'd10;
        qbyte[i] = 1'b1;
      end
      rem_c = t[3:0];
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) scale_r <= SCALE_RST;
    else if (cfg_we) scale_r <= cfg_wdata;
  end

  // line state
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear || cmd.write) begin
      phase_r <= PH_BLANK;
      mneg_r  <= 1'b0;
      iacc_r  <= '0;
      facc_r  <= '0;
      fdig_r  <= '0;
      emag_r  <= '0;
      eneg_r  <= 1'b0;
      len_r   <= '0;
    end else if (cmd.take) begin
      phase_r <= phase_nxt;
      mneg_r  <= mneg_nxt;
      iacc_r  <= iacc_nxt;
      facc_r  <= facc_nxt;
      fdig_r  <= fdig_nxt;
      emag_r  <= emag_nxt;
      eneg_r  <= eneg_nxt;
      len_r   <= len_inc;
    end else if (cmd.save_frac) begin
      facc_r <= wneg_r ? 64'd0 - w_r : w_r;
    end else if (cmd.save_int) begin
      iacc_r <= wneg_r ? 64'd0 - w_r : w_r;
    end
  end

  // scaling work register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + 3'd1;
    end
    if (cmd.setup) begin
      e_r    <= e_c;
      stat_r <= stat_c;
      val_r  <= '0;
    end
    if (cmd.load_frac) begin
      if (kf > 13'sd0) begin
        mode_div_r <= 1'b1;
        steps_r    <= (kf > 13'(DIV_CAP)) ? 5'(DIV_CAP) : kf[4:0];
        wneg_r     <= facc_r[63];
        w_r        <= facc_r[63] ? 64'd0 - facc_r : facc_r;
      end else begin
        mode_div_r <= 1'b0;
        steps_r    <= 5'(-kf);
        wneg_r     <= 1'b0;
        w_r        <= facc_r;
      end
    end
    if (cmd.load_int) begin
      if (e_r < 12'sd0) begin
        mode_div_r <= 1'b1;
        steps_r    <= (-e_r > 12'(DIV_CAP)) ? 5'(DIV_CAP) : 5'(-e_r);
        wneg_r     <= iacc_r[63];
        w_r        <= iacc_r[63] ? 64'd0 - iacc_r : iacc_r;
      end else begin
        mode_div_r <= 1'b0;
        steps_r    <= e_r[4:0];
        wneg_r     <= 1'b0;
        w_r        <= iacc_r;
      end
    end
    if (cmd.mul) begin
      w_r     <= times10(w_r);
      steps_r <= steps_r - 5'd1;
    end
    if (cmd.div_step) begin
      w_r   <= {w_r[55:0], qbyte};
      rem_r <= rem_c;
      if (div_cnt_r == 3'd7) steps_r <= steps_r - 5'd1;
    end
    if (cmd.sum) val_r <= iacc_r + facc_r;
    if (cmd.neg && mneg_r) val_r <= 64'd0 - val_r;
  end

  // history and result word
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      hcnt_r <= '0;
      for (int i = 0; i < 3; i++) hist_r[i] <= '0;
    end else if (cmd.write && stat_r == ST_OK) begin
      hist_r[0] <= val_r;
      hist_r[1] <= hist_r[0];
      hist_r[2] <= hist_r[1];
      if (hcnt_r != 2'd3) hcnt_r <= hcnt_r + 2'd1;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.write) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.write) begin
      out_r.parse_status <= stat_r;
      out_r.parsed_value <= (stat_r == ST_OK) ? val_r : 64'd0;
      if (stat_r == ST_OK && hcnt_r >= 2'd2) begin
        out_r.median_value <= med3(val_r, hist_r[0], hist_r[1]);
        out_r.median_valid <= 1'b1;
      end else begin
        out_r.median_value <= '0;
        out_r.median_valid <= 1'b0;
      end
    end
  end

  // status to the controller
  always_comb begin
    sts.req        = in_word.req_type;
    sts.term       = in_word.ch == CH_CR || in_word.ch == CH_LF;
    sts.full       = len_inc == LEN_W'(LINE_CHARS);
    sts.skip       = stat_c != ST_OK || e_c < 12'(MIN_EXP);
    sts.steps_zero = steps_r == 5'd0;
    sts.mode_div   = mode_div_r;
    sts.div_last   = div_cnt_r == 3'd7;
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  `SNPM3_AST_IMP(a_med_ok, out_valid_r && out_r.median_valid, out_r.parse_status == ST_OK)
  `SNPM3_AST_IMP(a_bad_zero, out_valid_r && out_r.parse_status != ST_OK,
                 out_r.parsed_value == 64'd0)
  `SNPM3_AST_NXT(a_div_wrap, cmd.div_step && div_cnt_r == 3'd7, div_cnt_r == 3'd0)

endmodule

### src/scpi_number_parse_median3_top.sv
// Characters: one word a cycle while idle; a word that does not end a line is taken without leaving idle.
// Line end: once the terminator (or the word that fills the store) is taken, the block scales
// the fraction then the integer part by multiply-by-ten or divide-by-ten steps (at most 20
// divides each), then sums, negates and writes the result; a bad line goes straight to the write.
// Input is held off during scaling and while a finished word still waits at the output.
// Synchronous active-low reset clears the line, the history and sets the scale to 3.
module scpi_number_parse_median3_top
  import snpm3_pkg::*;
#(
  parameter int LINE_CHARS = LINE_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_word,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  snpm3_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // parse, scaling and median datapath
  snpm3_dp #(
    .LINE_CHARS (LINE_CHARS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

### bench/scpi_number_parse_median3_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the scale register, predicts each line result
// and compares it with what the block returns.
module scpi_number_parse_median3_checker
  import snpm3_pkg::*;
#(
  parameter int LINE_CHARS = LINE_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_word_t   in_word,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_word_t  out_word,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  output int         errors,
  output int         pending,
  output int         lines_done
);

  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

  // predictor state
  logic [4:0]         scale;
  phase_t             phase;
  logic               neg_mant;
  logic [63:0]        int_acc;
  logic [63:0]        frac_acc;
  int                 frac_digits;
  int                 exp_mag;
  logic               neg_exp;
  int                 line_len;
  logic signed [63:0] hist [3];
  int                 hist_count;

  out_word_t result_q[$];

  assign pending = result_q.size();

  function automatic logic [63:0] div10_signed(logic [63:0] x);
    logic [63:0] m;
    if (x & SIGN_BIT) begin
      m = 64'd0 - x;
      return 64'd0 - (m / 64'd10);
    end
    return x / 64'd10;
  endfunction

  function automatic logic signed [63:0] median_of(logic signed [63:0] a,
                                                   logic signed [63:0] b,
                                                   logic signed [63:0] c);
    if ((b <= a && a <= c) || (c <= a && a <= b)) return a;
    if ((a <= b && b <= c) || (c <= b && b <= a)) return b;
    return c;
  endfunction

  task automatic reset_line();
    phase       = PH_BLANK;
    neg_mant    = 1'b0;
    int_acc     = '0;
    frac_acc    = '0;
    frac_digits = 0;
    exp_mag     = 0;
    neg_exp     = 1'b0;
    line_len    = 0;
  endtask

  task automatic reset_history();
    hist[0]    = '0;
    hist[1]    = '0;
    hist[2]    = '0;
    hist_count = 0;
  endtask

  // one character through the number grammar
  task automatic take_char(logic [7:0] c);
    logic        dig;
    logic [63:0] dv;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    dv  = 64'(c - CH_ZERO);
    case (phase)
      PH_BLANK: begin
        if (c == CH_SP || c == CH_TAB) begin
        end else if (c == CH_MINUS) begin
          neg_mant = 1'b1;
          phase    = PH_SIGN;
        end else if (c == CH_PLUS) begin
          phase = PH_SIGN;
        end else if (dig) begin
          int_acc = int_acc * 64'd10 + dv;
          phase   = PH_INT;
        end else if (c == CH_POINT) begin
          phase = PH_FRAC;
        end else begin
          phase = PH_BAD;
        end
      end
      PH_SIGN: begin
        if (dig) begin
          int_acc = int_acc * 64'd10 + dv;
          phase   = PH_INT;
        end else if (c == CH_POINT) phase = PH_FRAC;
        else phase = PH_BAD;
      end
      PH_INT: begin
        if (dig) int_acc = int_acc * 64'd10 + dv;
        else if (c == CH_POINT) phase = PH_FRAC;
        else if (c == CH_E_LO || c == CH_E_UP) phase = PH_EXPSIGN;
        else phase = PH_DONE;
      end
      PH_FRAC: begin
        if (dig) begin
          frac_acc = frac_acc * 64'd10 + dv;
          if (frac_digits < 255) frac_digits++;
        end else if (c == CH_E_LO || c == CH_E_UP) phase = PH_EXPSIGN;
        else phase = PH_DONE;
      end
      PH_EXPSIGN, PH_EXPDIG: begin
        if (dig) begin
          exp_mag = exp_mag * 10 + int'(dv);
          if (exp_mag > 1023) exp_mag = 1023;
          phase = PH_EXPDIG;
        end else if (phase == PH_EXPSIGN && c == CH_MINUS) begin
          neg_exp = 1'b1;
          phase   = PH_EXPDIG;
        end else if (phase == PH_EXPSIGN && c == CH_PLUS) begin
          phase = PH_EXPDIG;
        end else begin
          phase = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  endtask

  // line end: scale, update history, queue the expected word
  task automatic close_line();
    out_word_t   w;
    int          e;
    int          n;
    logic [63:0] ip;
    logic [63:0] fp;
    logic [63:0] val;
    w   = '0;
    val = '0;
    if (phase == PH_BLANK || phase == PH_SIGN || phase == PH_BAD) begin
      w.parse_status = ST_NAN;
    end else begin
      e = neg_exp ? -exp_mag : exp_mag;
      e = e + int'(scale);
      if (e > MAX_EXP) begin
        w.parse_status = ST_EXP;
      end else begin
        w.parse_status = ST_OK;
        if (e >= MIN_EXP) begin
          ip = int_acc;
          fp = frac_acc;
          n  = frac_digits;
          while (n > e) begin fp = div10_signed(fp); n--; end
          while (n < e) begin fp = fp * 64'd10; n++; end
          while (e > 0) begin ip = ip * 64'd10; e--; end
          while (e < 0) begin ip = div10_signed(ip); e++; end
          val = ip + fp;
          if (neg_mant) val = 64'd0 - val;
        end
      end
    end
    w.parsed_value = val;
    if (w.parse_status == ST_OK) begin
      hist[2] = hist[1];
      hist[1] = hist[0];
      hist[0] = val;
      if (hist_count >= 2) begin
        w.median_value = median_of(hist[0], hist[1], hist[2]);
        w.median_valid = 1'b1;
      end
      if (hist_count < 3) hist_count++;
    end
    result_q.push_back(w);
    reset_line();
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      scale = SCALE_RST;
      reset_line();
      reset_history();
      result_q.delete();
      errors     = 0;
      lines_done = 0;
    end else begin
      if (cfg_we) scale = cfg_wdata;

      // result side
      if (out_valid && out_ready) begin
        lines_done++;
        if (result_q.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          want = result_q.pop_front();
          if (out_word.parse_status !== want.parse_status) begin
            $error("parse_status: expected %0d, got %0d",
                   want.parse_status, out_word.parse_status);
            errors++;
          end
          if (out_word.parsed_value !== want.parsed_value) begin
            $error("parsed_value: expected %0d, got %0d",
                   want.parsed_value, out_word.parsed_value);
            errors++;
          end
          if (out_word.median_value !== want.median_value) begin
            $error("median_value: expected %0d, got %0d",
                   want.median_value, out_word.median_value);
            errors++;
          end
          if (out_word.median_valid !== want.median_valid) begin
            $error("median_valid: expected %0d, got %0d",
                   want.median_valid, out_word.median_valid);
            errors++;
          end
        end
      end

      // character side
      if (in_valid && in_ready) begin
        if (in_word.req_type) begin
          reset_line();
          reset_history();
        end else if (in_word.ch == CH_CR || in_word.ch == CH_LF) begin
          close_line();
        end else begin
          take_char(in_word.ch);
          line_len++;
          if (line_len >= LINE_CHARS) close_line();
        end
      end
    end
  end

endmodule

### bench/scpi_number_parse_median3_top_tb.sv
`timescale 1ns / 100ps

module scpi_number_parse_median3_top_tb;
  import snpm3_pkg::*;

  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 800;
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_WORDS  = 180;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_word_t   in_word = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_word_t  out_word;
  logic       cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;

  int errors;
  int pending;
  int lines_done;

  logic in_taken;
  int   snd_idle = 0;
  int   rcv_idle = 0;
  bit   hold_req = 1'b0;
  bit   hold_ack = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   words_sent = 0;
  int   clears_sent = 0;
  int   full_lines = 0;
  logic [7:0] line_buf[$];

  scpi_number_parse_median3_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  scpi_number_parse_median3_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending), .lines_done(lines_done)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // acceptance flag, seen by the sender at the following falling edge
  always_ff @(posedge clk) in_taken <= in_valid && in_ready;

  // watchdog on cycles with no word moved on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("scpi_number_parse_median3_top_tb: done, errors");
        $finish;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = LONG_HOLD;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic send_word(logic req, logic [7:0] c);
    while ($urandom_range(99) < snd_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_word  = '{req_type: req, ch: c};
    @(negedge clk);
    while (!in_taken) @(negedge clk);
    in_valid = 1'b0;
    words_sent++;
    if (req) clears_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
  endtask

  task automatic push_digits(int cnt);
    for (int i = 0; i < cnt; i++) line_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
  endtask

  // one random line into line_buf; mostly well-formed numbers
  task automatic build_line();
    int          kind;
    int          k;
    logic [7:0]  junk[9];
    junk = '{CH_PLUS, CH_MINUS, CH_POINT, CH_E_LO, CH_E_UP, CH_ZERO, CH_NINE, CH_SP, 8'h78};
    line_buf.delete();
    kind = $urandom_range(99);
    if (kind < 70) begin
      k = $urandom_range(3);
      repeat (k == 3 ? 2 : k) line_buf.push_back($urandom_range(1) ? CH_SP : CH_TAB);
      k = $urandom_range(2);
      if (k == 1) line_buf.push_back(CH_MINUS);
      else if (k == 2) line_buf.push_back(CH_PLUS);
      push_digits($urandom_range(15) == 0 ? $urandom_range(18, 26) : $urandom_range(0, 5));
      if ($urandom_range(1)) begin
        line_buf.push_back(CH_POINT);
        push_digits($urandom_range(20) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 5));
      end
      if ($urandom_range(2) == 0) begin
        line_buf.push_back($urandom_range(1) ? CH_E_LO : CH_E_UP);
        k = $urandom_range(2);
        if (k == 1) line_buf.push_back(CH_MINUS);
        else if (k == 2) line_buf.push_back(CH_PLUS);
        push_digits($urandom_range(9) == 0 ? $urandom_range(3, 5) : $urandom_range(1, 2));
      end
      if ($urandom_range(4) == 0) begin
        line_buf.push_back(8'($urandom_range(255)));
        line_buf.push_back(junk[$urandom_range(8)]);
      end
      line_buf.push_back($urandom_range(1) ? CH_CR : CH_LF);
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 6)) line_buf.push_back(junk[$urandom_range(8)]);
      line_buf.push_back($urandom_range(1) ? CH_CR : CH_LF);
    end else if (kind < 95) begin
      repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(255)));
      line_buf.push_back(CH_LF);
    end else if (kind < 98 || full_lines >= 3) begin
      // empty buffer marks a clear request
    end else begin
      // no terminator: the line store limit ends the line; CR and LF kept out
      full_lines++;
      push_digits($urandom_range(1, 30));
      line_buf.push_back(CH_POINT);
      while (line_buf.size() < LINE_CHARS_DEF) begin
        k = $urandom_range(255);
        line_buf.push_back((k == CH_CR || k == CH_LF) ? 8'h78 : 8'(k));
      end
    end
  endtask

  task automatic random_words(int target);
    int stop_at;
    stop_at = words_sent + target;
    while (words_sent < stop_at) begin
      build_line();
      if (line_buf.size() == 0) send_word(1'b1, 8'($urandom_range(255)));
      else foreach (line_buf[i]) send_word(1'b0, line_buf[i]);
    end
  endtask

  // let every line finish, then the scaling loop of a line with no result
  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_scale(logic [4:0] v);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  initial begin
    logic [4:0] scales[6];
    int         idle_mode;
    scales = '{5'd0, 5'd16, 5'd31, 5'd6, 5'($urandom_range(1, 15)), 5'd3};
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed lines at the reset scale
    snd_idle = 20;
    rcv_idle = 67;
    send_text("1.5\n");
    send_text("-.2E+1\r");
    send_text("\n");
    send_text("-\n");
    send_text(" 7z\n");
    send_text("9e99\n");
    send_word(1'b1, 8'hFF);

    for (int p = 0; p < 6; p++) begin
      settle();
      write_scale(scales[p]);
      idle_mode = p / 2;
      snd_idle = (idle_mode == 0) ? 20 : (idle_mode == 1) ? 67 : 0;
      rcv_idle = (idle_mode == 0) ? 67 : (idle_mode == 1) ? 20 : 0;
      if (p == 4) hold_req = ~hold_req;
      random_words(PHASE_WORDS);
    end
    settle();

    $display("covered %0d words (%0d clears, %0d full-store lines), %0d line results",
             words_sent, clears_sent, full_lines, lines_done);
    $display("scale settings 3, 0, 16, 31, 6, random and 3; three stall mixes and a long hold-off");
    if (errors == 0) begin
      $display("scpi_number_parse_median3_top_tb: done, clean");
    end else begin
      $display("scpi_number_parse_median3_top_tb: done, errors");
    end
    $finish;
  end

endmodule
